[hdl/mcet_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcet_pkg: shared types and constants of the multi-channel event timer
// Field widths, reset values, the item kind codes and the result record.
// ----------------------------------------------------------------------------

package mcet_pkg;

  // Field widths.
  localparam int KIND_W    = 2;
  localparam int CHANNEL_W = 3;
  localparam int PERIOD_W  = 16;
  localparam int TIME_W    = 32;

  // Default number of timer channels.
  localparam int NUM_TIMERS_DEFAULT = 8;

  // Count and reload value of every channel after reset.
  localparam logic [PERIOD_W-1:0] RESET_PERIOD = 16'd1024;

  // Scale factor of the reported time in multiply mode.
  localparam logic [TIME_W-1:0] SCALE_MULT = 32'd20;

  // Item kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_TICK       = 2'd0,
    KIND_SET_PERIOD = 2'd1,
    KIND_CLEAR_FLAG = 2'd2,
    KIND_READ       = 2'd3
  } kind_e;

  // One result item.
  typedef struct packed {
    logic              flag;
    logic [TIME_W-1:0] time_res;
  } result_t;

endpackage

[hdl/mcet_bank.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcet_bank: timer channel state and system tick count
// Holds every channel's counter, reload value and flag, applies one item per
// cycle and forms that item's result from the state before the update.
// ----------------------------------------------------------------------------

module mcet_bank #(
  parameter int NUM_TIMERS = mcet_pkg::NUM_TIMERS_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               accept_i,
  input  mcet_pkg::kind_e                    kind_i,
  input  logic [mcet_pkg::CHANNEL_W-1:0]     channel_i,
  input  logic [mcet_pkg::PERIOD_W-1:0]      period_i,
  input  logic                               scale_mode_i,
  output mcet_pkg::result_t                  result_o
);

  logic [mcet_pkg::PERIOD_W-1:0] count_q  [NUM_TIMERS];
  logic [mcet_pkg::PERIOD_W-1:0] count_d  [NUM_TIMERS];
  logic [mcet_pkg::PERIOD_W-1:0] reload_q [NUM_TIMERS];
  logic [mcet_pkg::PERIOD_W-1:0] reload_d [NUM_TIMERS];
  logic [NUM_TIMERS-1:0]         flag_q;
  logic [NUM_TIMERS-1:0]         flag_d;
  logic [mcet_pkg::TIME_W-1:0]   tick_q;
  logic [mcet_pkg::TIME_W-1:0]   tick_d;
  logic [NUM_TIMERS-1:0]         hit;

  // One-hot match of the addressed channel; a channel number beyond the bank
  // matches no lane, so it reads a zero flag and changes nothing.
  always_comb begin
    for (int i = 0; i < NUM_TIMERS; i++) begin
      hit[i] = (32'(channel_i) == i);
    end
  end

  always_comb begin
    tick_d = tick_q;
    if (accept_i && (kind_i == mcet_pkg::KIND_TICK)) begin
      tick_d = tick_q + mcet_pkg::TIME_W'(1);
    end
    for (int i = 0; i < NUM_TIMERS; i++) begin
      count_d[i]  = count_q[i];
      reload_d[i] = reload_q[i];
      flag_d[i]   = flag_q[i];
      if (accept_i) begin
        case (kind_i)
          mcet_pkg::KIND_TICK: begin
            if (count_q[i] != '0) begin
              count_d[i] = count_q[i] - mcet_pkg::PERIOD_W'(1);
            end else begin
              count_d[i] = reload_q[i];
              flag_d[i]  = 1'b1;
            end
          end
          mcet_pkg::KIND_SET_PERIOD: begin
            if (hit[i]) begin
              count_d[i]  = period_i;
              reload_d[i] = period_i;
              flag_d[i]   = 1'b0;
            end
          end
          mcet_pkg::KIND_CLEAR_FLAG: begin
            if (hit[i]) begin
              flag_d[i] = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        count_q[i]  <= mcet_pkg::RESET_PERIOD;
        reload_q[i] <= mcet_pkg::RESET_PERIOD;
      end
      flag_q <= '0;
      tick_q <= '0;
    end else begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        count_q[i]  <= count_d[i];
        reload_q[i] <= reload_d[i];
      end
      flag_q <= flag_d;
      tick_q <= tick_d;
    end
  end

  // Result from the state before this item's update.
  always_comb begin
    result_o.flag = |(flag_q & hit);
    if (scale_mode_i) begin
      result_o.time_res = tick_q * mcet_pkg::SCALE_MULT;
    end else begin
      result_o.time_res = tick_q >> 1;
    end
  end

endmodule

[hdl/mcet_out_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcet_out_stage: result register with a skid entry
// Holds the presented result and one more, so the input side can take one
// more item while the consumer stalls.
// ----------------------------------------------------------------------------

module mcet_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mcet_pkg::result_t push_data_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mcet_pkg::result_t out_data_o
);

  logic              out_valid_q;
  logic              out_valid_d;
  mcet_pkg::result_t out_data_q;
  mcet_pkg::result_t out_data_d;
  logic              skid_valid_q;
  logic              skid_valid_d;
  mcet_pkg::result_t skid_data_q;
  mcet_pkg::result_t skid_data_d;
  logic              out_free;

  // The output register can load when it is empty or its transfer completes.
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push_i;
        out_data_d  = push_data_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_data_d  = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[hdl/multi_channel_event_timer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_event_timer: bank of periodic event timers with a system tick
// Each item ticks all channels, sets a channel's period, clears a channel's
// flag or only reads; every item returns one result with the addressed
// channel's flag and the scaled system time, both as they were before it.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Payload
//   input     in         in_valid_i/in_stall_o  kind_i, channel_i, period_i
//   output    out        out_valid_o/out_stall_i flag_o, time_res_o
//   config    in         cfg_we_i               cfg_wdata_i (time scale mode)
//
// One item per cycle while in_stall_o is low: the whole update and result are
// one pass of logic from the accepted item and the channel registers into the
// result register, or into the skid entry while the consumer stalls.
// Reset clears the tick count, all flags and the mode, and loads every
// channel's count and reload value with 1024.
// A skid entry behind the result register lets one more item in while the
// consumer stalls; in_stall_o rises only once that entry is occupied.
//
// The period of a channel is its reload value plus one ticks: a channel at
// zero reloads and sets its sticky flag instead of decrementing. The mode
// register selects the reported time as the tick count shifted right by one,
// or the tick count times twenty truncated to 32 bits.

module multi_channel_event_timer #(
  parameter int NUM_TIMERS = mcet_pkg::NUM_TIMERS_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port.
  input  logic                           cfg_we_i,
  input  logic                           cfg_wdata_i,
  // Input channel.
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [mcet_pkg::KIND_W-1:0]    kind_i,
  input  logic [mcet_pkg::CHANNEL_W-1:0] channel_i,
  input  logic [mcet_pkg::PERIOD_W-1:0]  period_i,
  // Output channel.
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           flag_o,
  output logic [mcet_pkg::TIME_W-1:0]    time_res_o
);

  logic              scale_mode_q;
  logic              in_accept;
  logic              skid_full;
  mcet_pkg::result_t result;
  mcet_pkg::result_t out_data;

  // Time scale mode register; the user must write it only while the block is idle, the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      scale_mode_q <= cfg_wdata_i;
    end
  end

  // An input transfer completes whenever the skid entry is free.
  assign in_stall_o = skid_full;
  assign in_accept  = in_valid_i && !skid_full;

  mcet_bank #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_bank (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_accept),
    .kind_i       (mcet_pkg::kind_e'(kind_i)),
    .channel_i    (channel_i),
    .period_i     (period_i),
    .scale_mode_i (scale_mode_q),
    .result_o     (result)
  );

  mcet_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_accept),
    .push_data_i (result),
    .full_o      (skid_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign flag_o     = out_data.flag;
  assign time_res_o = out_data.time_res;

endmodule

[tb/sv/mcet_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcet_checker: result predictor and scoreboard for the event timer bank
// Watches the configuration port and both channels, keeps a private model of
// the channel counters, flags and system tick count, and compares every
// result transfer against the oldest predicted result.
// ----------------------------------------------------------------------------

module mcet_checker #(
  parameter int NUM_TIMERS = mcet_pkg::NUM_TIMERS_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_wdata_i,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [mcet_pkg::KIND_W-1:0]    kind_i,
  input  logic [mcet_pkg::CHANNEL_W-1:0] channel_i,
  input  logic [mcet_pkg::PERIOD_W-1:0]  period_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic                           flag_i,
  input  logic [mcet_pkg::TIME_W-1:0]    time_res_i,
  output int                             fail_count_o,
  output int                             pending_o
);

  import mcet_pkg::*;

  logic [PERIOD_W-1:0] down_count   [NUM_TIMERS];
  logic [PERIOD_W-1:0] reload_value [NUM_TIMERS];
  logic                expired      [NUM_TIMERS];
  logic [TIME_W-1:0]   tick_total;
  logic                scale_mode;
  result_t             expected_results [$];
  int                  mismatches;

  function automatic logic [TIME_W-1:0] reported_time(logic [TIME_W-1:0] ticks, logic mode);
    logic [TIME_W-1:0] scaled;
    if (mode) begin
      scaled = ticks * SCALE_MULT;
    end else begin
      scaled = ticks >> 1;
    end
    return scaled;
  endfunction

  // Predicts the result of one input transfer, then applies its effect.
  task automatic timer_step(kind_e op, logic [CHANNEL_W-1:0] ch, logic [PERIOD_W-1:0] per);
    result_t res;
    bit      hit;
    hit          = int'(ch) < NUM_TIMERS;
    res.flag     = hit ? expired[ch] : 1'b0;
    res.time_res = reported_time(tick_total, scale_mode);
    expected_results.push_back(res);
    case (op)
      KIND_TICK: begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (down_count[i] != '0) begin
            down_count[i] = down_count[i] - 1'b1;
          end else begin
            down_count[i] = reload_value[i];
            expired[i]    = 1'b1;
          end
        end
        tick_total = tick_total + 1'b1;
      end
      KIND_SET_PERIOD: begin
        if (hit) begin
          down_count[ch]   = per;
          reload_value[ch] = per;
          expired[ch]      = 1'b0;
        end
      end
      KIND_CLEAR_FLAG: begin
        if (hit) begin
          expired[ch] = 1'b0;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_result(logic got_flag, logic [TIME_W-1:0] got_time);
    result_t want;
    if (expected_results.size() == 0) begin
      $error("result transfer with no prediction pending: flag %0d time_res %0d",
             got_flag, got_time);
      mismatches++;
    end else begin
      want = expected_results.pop_front();
      if (got_flag !== want.flag) begin
        $error("flag mismatch: expected %0d, actual %0d", want.flag, got_flag);
        mismatches++;
      end
      if (got_time !== want.time_res) begin
        $error("time_res mismatch: expected %0d, actual %0d", want.time_res, got_time);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        down_count[i]   = RESET_PERIOD;
        reload_value[i] = RESET_PERIOD;
        expired[i]      = 1'b0;
      end
      tick_total = '0;
      scale_mode = 1'b0;
      expected_results.delete();
      mismatches = 0;
    end else begin
      // Results leave through the output register, never in the cycle of their
      // input, so the output side is settled before this edge's input is predicted.
      if (out_valid_i && !out_stall_i) begin
        check_result(flag_i, time_res_i);
      end
      if (cfg_we_i) begin
        scale_mode = cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_i) begin
        timer_step(kind_e'(kind_i), channel_i, period_i);
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_results.size();
  end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top-level testbench of the multi-channel event timer
// Drives directed and random items with random idle gaps on the input and
// random stalls on the output, writes the time scale mode between phases,
// and reports the verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------

module tb;

  import mcet_pkg::*;

  localparam int NUM_TIMERS     = NUM_TIMERS_DEFAULT;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 280;
  // Long receiver hold-off: far longer than the two entries of buffering in
  // the block, so its input stall must rise while the sender keeps offering.
  localparam int HOLD_CYCLES    = 64;
  // The slowest correct stretch without any transfer is a hold-off or a long
  // stall run lined up with a long sender gap.
  localparam int WATCHDOG_LIMIT = 1000;
  // Margin after the drain finds no result pending.
  localparam int DRAIN_CYCLES   = 4;
  localparam int SETTLE_CYCLES  = 10;
  // One channel keeps its reset period until enough ticks have gone by for
  // it to expire from the 1024 loaded at reset.
  localparam int KEEP_CHANNEL   = 6;
  localparam int KEEP_TICKS     = 1100;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic                 cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  kind_e                kind;
  logic [CHANNEL_W-1:0] channel;
  logic [PERIOD_W-1:0]  period;
  logic                 out_valid;
  logic                 out_stall;
  logic                 flag;
  logic [TIME_W-1:0]    time_res;

  int fail_count;
  int pending;
  int ticks_sent;
  int idle_cycles;
  int holds_requested;
  int holds_served;
  bit calm;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  multi_channel_event_timer #(
    .NUM_TIMERS(NUM_TIMERS)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .kind_i     (kind),
    .channel_i  (channel),
    .period_i   (period),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .flag_o     (flag),
    .time_res_o (time_res)
  );

  mcet_checker #(
    .NUM_TIMERS(NUM_TIMERS)
  ) checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .kind_i      (kind),
    .channel_i   (channel),
    .period_i    (period),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .flag_i      (flag),
    .time_res_i  (time_res),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Idle gap after an input transfer: mostly none or short, now and then long.
  // Calm phases run back to back so the block sees one item every cycle.
  function automatic int idle_gap();
    int pick;
    if (calm) begin
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      return 0;
    end else if (pick < 90) begin
      return $urandom_range(1, 2);
    end else if (pick < 98) begin
      return $urandom_range(3, 8);
    end
    return $urandom_range(15, 40);
  endfunction

  // Offers one item and holds it until the block takes it. Valid stays high
  // into the next item when no gap follows, so back-to-back transfers happen.
  task automatic push_item(kind_e op, logic [CHANNEL_W-1:0] ch, logic [PERIOD_W-1:0] per);
    int gap;
    in_valid <= 1'b1;
    kind     <= op;
    channel  <= ch;
    period   <= per;
    do @(posedge clk); while (in_stall);
    if (op == KIND_TICK) begin
      ticks_sent++;
    end
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random item: ticks dominate so channels expire and reload often; set
  // items mostly use short periods so flags rise within a few ticks, with
  // zero, the largest period and full-range values mixed in.
  task automatic push_random();
    int                   pick;
    kind_e                op;
    logic [CHANNEL_W-1:0] ch;
    logic [PERIOD_W-1:0]  per;
    pick = $urandom_range(0, 99);
    ch   = CHANNEL_W'($urandom_range(0, 7));
    per  = PERIOD_W'($urandom);
    if (pick < 70) begin
      op = KIND_TICK;
    end else if (pick < 82) begin
      op = KIND_SET_PERIOD;
      while (ch == KEEP_CHANNEL && ticks_sent < KEEP_TICKS) begin
        ch = CHANNEL_W'($urandom_range(0, 7));
      end
      case ($urandom_range(0, 9))
        0: per = '0;
        1: per = '1;
        2: per = PERIOD_W'($urandom);
        default: per = PERIOD_W'($urandom_range(0, 12));
      endcase
    end else if (pick < 91) begin
      op = KIND_CLEAR_FLAG;
    end else begin
      op = KIND_READ;
    end
    push_item(op, ch, per);
  endtask

  // Stops offering and waits until every predicted result has come back.
  // The pending count is registered, so the first look waits for a clock edge.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // The mode register is only written while the block is idle.
  task automatic write_mode(logic mode);
    cfg_wdata <= mode;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Receiver: alternating runs of accept and stall. A hold-off request from
  // the stimulus process takes priority and keeps stall high for a long
  // stretch; calm phases start no new stall run.
  initial begin
    int run_left;
    bit level;
    run_left     = 0;
    level        = 1'b0;
    holds_served = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (run_left == 0) begin
        if (holds_served < holds_requested) begin
          level    = 1'b1;
          run_left = HOLD_CYCLES;
          holds_served++;
        end else if (calm) begin
          level    = 1'b0;
          run_left = $urandom_range(4, 16);
        end else begin
          case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
              level    = 1'b0;
              run_left = $urandom_range(1, 6);
            end
            19: begin
              level    = 1'b1;
              run_left = $urandom_range(10, 30);
            end
            default: begin
              level    = 1'b1;
              run_left = $urandom_range(1, 3);
            end
          endcase
        end
      end
      out_stall <= level;
      run_left--;
    end
  end

  // Watchdog: any transfer on either channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    ticks_sent      = 0;
    holds_requested = 0;
    calm            = 1'b0;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= 1'b0;
    in_valid  <= 1'b0;
    kind      <= KIND_READ;
    channel   <= '0;
    period    <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, shift mode. Every kind, channels at both ends, periods
    // of zero, one and the maximum, and period and channel bits on items
    // that must ignore them.
    write_mode(1'b0);
    push_item(KIND_READ,       3'd0, 16'hFFFF);  // period ignored on a read
    push_item(KIND_SET_PERIOD, 3'd0, 16'h0000);  // zero reload expires every tick
    push_item(KIND_SET_PERIOD, 3'd7, 16'hFFFF);  // largest period
    push_item(KIND_SET_PERIOD, 3'd3, 16'h0001);
    push_item(KIND_CLEAR_FLAG, 3'd5, 16'hFFFF);  // clearing a flag that is clear
    push_item(KIND_TICK,       3'd7, 16'hFFFF);  // tick ignores channel and period
    push_item(KIND_TICK,       3'd0, 16'h0000);  // channel 0 flag now reported set
    push_item(KIND_TICK,       3'd3, 16'hAAAA);
    push_item(KIND_READ,       3'd3, 16'h5555);
    push_item(KIND_CLEAR_FLAG, 3'd0, 16'h5555);
    push_item(KIND_READ,       3'd0, 16'hAAAA);
    push_item(KIND_TICK,       3'd0, 16'h0000);
    push_item(KIND_READ,       3'd0, 16'h0000);
    push_item(KIND_SET_PERIOD, 3'd3, 16'h0002);  // set also clears the flag
    push_item(KIND_READ,       3'd3, 16'h0000);
    push_item(KIND_SET_PERIOD, 3'd1, 16'h8000);
    push_item(KIND_TICK,       3'd1, 16'h7FFF);
    push_item(KIND_TICK,       3'd2, 16'h0000);
    push_item(KIND_TICK,       3'd4, 16'hFFFF);
    push_item(KIND_READ,       3'd7, 16'h0000);
    push_item(KIND_CLEAR_FLAG, 3'd7, 16'h0000);
    push_item(KIND_READ,       3'd5, 16'hFFFF);
    drain();

    // Random phases. The mode alternates between its two settings, phase 2
    // runs with no idling on either side, and phases 0 and 4 open with a
    // long receiver hold-off while the sender keeps offering items.
    for (int phase = 0; phase < PHASES; phase++) begin
      calm = (phase == 2);
      write_mode(phase % 2 == 0);
      if (phase == 0 || phase == 4) begin
        holds_requested++;
      end
      repeat (PHASE_ITEMS) push_random();
      drain();
    end
    calm = 1'b0;

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/mcet_pkg.sv
hdl/mcet_bank.sv
hdl/mcet_out_stage.sv
hdl/multi_channel_event_timer.sv
tb/sv/mcet_checker.sv
tb/sv/tb.sv
